// ===== rtl/qau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, codes and arithmetic helpers of the quaternion attitude unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int CW    = 32;                  // stored component width
	localparam int OP_W  = (CW > 32) ? CW : 32; // multiplier operand width
	localparam int MW    = OP_W + 1;            // signed multiplier input width
	localparam int WIDE  = 2 * MW;              // product and sum width
	localparam int ACC_W = 2 * OP_W - 16;       // quaternion product accumulator

	typedef logic signed [CW-1:0]   comp_t;
	typedef logic signed [OP_W-1:0] op_t;
	typedef logic signed [WIDE-1:0] wide_t;
	typedef logic [CW-1:0]          cmag_t;

	localparam logic [1:0] FN_INTEG = 2'd0;
	localparam logic [1:0] FN_R2B   = 2'd1;
	localparam logic [1:0] FN_B2R   = 2'd2;
	localparam logic [1:0] FN_LOAD  = 2'd3;

	localparam logic [2:0] REG_INIT_W   = 3'd0;
	localparam logic [2:0] REG_INIT_X   = 3'd1;
	localparam logic [2:0] REG_INIT_Y   = 3'd2;
	localparam logic [2:0] REG_INIT_Z   = 3'd3;
	localparam logic [2:0] REG_TIMESTEP = 3'd4;
	localparam logic [2:0] REG_SUBSTEPS = 3'd5;

	// one term of the hamilton product: operand indexes (w,x,y,z = 0..3), sign
	typedef struct packed {
		logic [1:0] ai;
		logic [1:0] bi;
		logic       neg;
	} term_t;

	// terms grouped four per result component, in order w, x, y, z
	function automatic term_t hp_term(input logic [3:0] k);
		term_t t;
		unique case (k)
			4'd0:    t = '{2'd1, 2'd1, 1'b1};
			4'd1:    t = '{2'd2, 2'd2, 1'b1};
			4'd2:    t = '{2'd3, 2'd3, 1'b1};
			4'd3:    t = '{2'd0, 2'd0, 1'b0};
			4'd4:    t = '{2'd0, 2'd1, 1'b0};
			4'd5:    t = '{2'd3, 2'd2, 1'b1};
			4'd6:    t = '{2'd2, 2'd3, 1'b0};
			4'd7:    t = '{2'd1, 2'd0, 1'b0};
			4'd8:    t = '{2'd3, 2'd1, 1'b0};
			4'd9:    t = '{2'd0, 2'd2, 1'b0};
			4'd10:   t = '{2'd1, 2'd3, 1'b1};
			4'd11:   t = '{2'd2, 2'd0, 1'b0};
			4'd12:   t = '{2'd2, 2'd1, 1'b1};
			4'd13:   t = '{2'd1, 2'd2, 1'b0};
			4'd14:   t = '{2'd0, 2'd3, 1'b0};
			default: t = '{2'd3, 2'd0, 1'b0};
		endcase
		return t;
	endfunction

	function automatic comp_t sat_cw(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);
		lo = -(wide_t'(1) <<< (CW - 1));
		if (v > hi)
			return comp_t'(hi);
		else if (v < lo)
			return comp_t'(lo);
		return comp_t'(v);
	endfunction

	function automatic logic signed [31:0] sat_32(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< 31) - wide_t'(1);
		lo = -(wide_t'(1) <<< 31);
		if (v > hi)
			return 32'sh7fff_ffff;
		else if (v < lo)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic cmag_t cmag(input comp_t v);
		return v[CW-1] ? cmag_t'(-v) : cmag_t'(v);
	endfunction

endpackage

// ===== rtl/quaternion_attitude_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_unit
// Keeps an attitude quaternion; integrates body rates with euler substeps,
// rotates vectors between frames, or reloads the attitude from registers.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  vector  | vec_valid, vec_stall, func, vec_x/y/z     | in
//  result  | res_valid, res_stall, out_w/x/y/z         | out
//  config  | cfg_wr_en, cfg_index, cfg_data            | in
//
//  one shared 33x33 multiplier, a shift-subtract divider and a square root
//  stepper run under one sequencer; each product is registered before use;
//  integration is dominated by the 32-step square root and four 31-step
//  divides per substep
//  vec_stall is high from the accepted transaction until its result is in the
//  output register; a stalled result holds the next one back in its last state
//  reset restores the identity attitude and the register defaults
// ----------------------------------------------------------------------------
module quaternion_attitude_unit import qau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] out_w,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_HDIV   = 4'd1;
	localparam logic [3:0] S_HP     = 4'd2;
	localparam logic [3:0] S_HPEND  = 4'd3;
	localparam logic [3:0] S_SCALE  = 4'd4;
	localparam logic [3:0] S_NMAG   = 4'd5;
	localparam logic [3:0] S_NSHIFT = 4'd6;
	localparam logic [3:0] S_NSQ    = 4'd7;
	localparam logic [3:0] S_SQRT   = 4'd8;
	localparam logic [3:0] S_NDIV   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]         state_q;
	logic [1:0]         fn_q;
	logic               pass_q;
	logic               sh30_q;
	logic               ph_q;
	logic [3:0]         k_q;
	logic [1:0]         idx_q;
	logic [5:0]         cnt_q;
	logic [7:0]         step_q;
	logic               res_valid_q;

	logic signed [31:0] init_w_q, init_x_q, init_y_q, init_z_q;
	logic [31:0]        time_step_q;
	logic [7:0]         substeps_q;

	comp_t              orient_q [4];
	comp_t              t_q [4];
	op_t                opa_q [4];
	op_t                opb_q [4];
	op_t                vec_q [4];
	cmag_t              c_q [4];
	logic [3:0]         sg_q;
	logic signed [ACC_W-1:0] acc_q;
	wide_t              prod_q;
	logic [63:0]        rem_q, dsr_q, quo_q;
	logic [32:0]        norm_q;
	logic [31:0]        h_q;
	logic signed [31:0] out_w_q, out_x_q, out_y_q, out_z_q;

	term_t              term;
	logic signed [MW-1:0] mul_a, mul_b;
	wide_t              mul_p;
	wide_t              hp_val, hp_sum, sc_sum, nd_val;
	logic               div_ge, sq_ge;
	logic [63:0]        sq_trial;
	logic [7:0]         steps;
	logic               big;

	assign steps = (substeps_q == 8'd0) ? 8'd1 : substeps_q;
	assign term  = hp_term(k_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_HP: begin
				mul_a = MW'(opa_q[term.ai]);
				mul_b = MW'(opb_q[term.bi]);
			end
			S_SCALE: begin
				mul_a = MW'(t_q[idx_q]);
				mul_b = MW'($signed({1'b0, h_q}));
			end
			S_NSQ: begin
				mul_a = $signed(MW'(c_q[idx_q]));
				mul_b = $signed(MW'(c_q[idx_q]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// floor shift of the registered product, then signed accumulate
	assign hp_val = prod_q >>> (sh30_q ? 30 : 20);
	assign hp_sum = WIDE'(acc_q) + (term.neg ? -hp_val : hp_val);
	assign sc_sum = WIDE'(orient_q[idx_q]) + (prod_q >>> 25);
	assign nd_val = sg_q[idx_q] ? -$signed(WIDE'(quo_q)) : $signed(WIDE'(quo_q));

	assign div_ge   = rem_q >= dsr_q;
	assign sq_trial = quo_q + dsr_q;
	assign sq_ge    = rem_q >= sq_trial;

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 4; i++)
			if (64'(c_q[i]) >= 64'h8000_0000)
				big = 1'b1;
	end

	always_ff @(posedge clk) prod_q <= mul_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_w_q    <= 32'sh4000_0000;
			init_x_q    <= '0;
			init_y_q    <= '0;
			init_z_q    <= '0;
			time_step_q <= 32'd167772;
			substeps_q  <= 8'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_INIT_W:   init_w_q    <= cfg_data;
				REG_INIT_X:   init_x_q    <= cfg_data;
				REG_INIT_Y:   init_y_q    <= cfg_data;
				REG_INIT_Z:   init_z_q    <= cfg_data;
				REG_TIMESTEP: time_step_q <= cfg_data;
				REG_SUBSTEPS: substeps_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (vec_valid) begin
					vec_q[0] <= '0;
					vec_q[1] <= op_t'(vec_x);
					vec_q[2] <= op_t'(vec_y);
					vec_q[3] <= op_t'(vec_z);
					acc_q    <= '0;
					rem_q    <= 64'(time_step_q);
					dsr_q    <= 64'(steps) << 31;
					quo_q    <= '0;
					opa_q[0] <= '0;
					opa_q[1] <= op_t'(vec_x);
					opa_q[2] <= op_t'(vec_y);
					opa_q[3] <= op_t'(vec_z);
					for (int i = 0; i < 4; i++)
						opb_q[i] <= (func == FN_B2R && i != 0) ?
							op_t'(sat_cw(-WIDE'(orient_q[i]))) : op_t'(orient_q[i]);
				end
			end
			S_HDIV: begin
				if (cnt_q != '0) begin
					if (div_ge)
						rem_q <= rem_q - dsr_q;
					quo_q <= {quo_q[62:0], div_ge};
					dsr_q <= dsr_q >> 1;
				end else begin
					h_q <= quo_q[31:0];
					for (int i = 0; i < 4; i++) begin
						opa_q[i] <= op_t'(orient_q[i]);
						opb_q[i] <= vec_q[i];
					end
					acc_q <= '0;
				end
			end
			S_HP: begin
				if (ph_q) begin
					if (k_q[1:0] == 2'd3) begin
						t_q[k_q[3:2]] <= sat_cw(hp_sum);
						acc_q         <= '0;
					end else begin
						acc_q <= ACC_W'(hp_sum);
					end
				end
			end
			S_HPEND: begin
				for (int i = 0; i < 4; i++) begin
					opb_q[i] <= op_t'(t_q[i]);
					if (fn_q == FN_R2B && i != 0)
						opa_q[i] <= op_t'(sat_cw(-WIDE'(orient_q[i])));
					else
						opa_q[i] <= op_t'(orient_q[i]);
				end
				acc_q <= '0;
			end
			S_NMAG: begin
				for (int i = 0; i < 4; i++) begin
					c_q[i]  <= cmag(orient_q[i]);
					sg_q[i] <= orient_q[i][CW-1];
				end
			end
			S_NSHIFT: begin
				if (big) begin
					for (int i = 0; i < 4; i++)
						c_q[i] <= c_q[i] >> 1;
				end else begin
					rem_q <= '0;
				end
			end
			S_NSQ: begin
				if (ph_q) begin
					rem_q <= rem_q + prod_q[63:0];
					if (idx_q == 2'd3) begin
						dsr_q <= 64'd1 << 62;
						quo_q <= '0;
					end
				end
			end
			S_SQRT: begin
				if (cnt_q != '0) begin
					if (sq_ge) begin
						rem_q <= rem_q - sq_trial;
						quo_q <= (quo_q >> 1) + dsr_q;
					end else begin
						quo_q <= quo_q >> 1;
					end
					dsr_q <= dsr_q >> 2;
				end else begin
					norm_q <= quo_q[32:0];
				end
			end
			S_NDIV: begin
				if (!ph_q) begin
					rem_q <= 64'(c_q[idx_q]) << 30;
					dsr_q <= 64'(norm_q) << 30;
					quo_q <= '0;
				end else if (cnt_q != '0) begin
					if (div_ge)
						rem_q <= rem_q - dsr_q;
					quo_q <= {quo_q[62:0], div_ge};
					dsr_q <= dsr_q >> 1;
				end else if (idx_q == 2'd3 && step_q != steps - 8'd1) begin
					for (int i = 0; i < 4; i++) begin
						opa_q[i] <= (i == 3) ? op_t'(sat_cw(nd_val)) : op_t'(orient_q[i]);
						opb_q[i] <= vec_q[i];
					end
					acc_q <= '0;
				end
			end
			S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					if (fn_q == FN_R2B || fn_q == FN_B2R) begin
						out_w_q <= sat_32(WIDE'(t_q[0]));
						out_x_q <= sat_32(WIDE'(t_q[1]));
						out_y_q <= sat_32(WIDE'(t_q[2]));
						out_z_q <= sat_32(WIDE'(t_q[3]));
					end else begin
						out_w_q <= sat_32(WIDE'(orient_q[0]));
						out_x_q <= sat_32(WIDE'(orient_q[1]));
						out_y_q <= sat_32(WIDE'(orient_q[2]));
						out_z_q <= sat_32(WIDE'(orient_q[3]));
					end
				end
			end
			default: ;
		endcase
		// zero-norm substep restarts from the unchanged attitude
		if (state_q == S_SQRT && cnt_q == '0 && quo_q == '0) begin
			for (int i = 0; i < 4; i++) begin
				opa_q[i] <= op_t'(orient_q[i]);
				opb_q[i] <= vec_q[i];
			end
			acc_q <= '0;
		end
	end

	// sequencer and attitude state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fn_q        <= FN_INTEG;
			pass_q      <= 1'b0;
			sh30_q      <= 1'b0;
			ph_q        <= 1'b0;
			k_q         <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			orient_q[0] <= sat_cw(wide_t'(1) <<< 30);
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else begin
			if (state_q == S_DONE && (!res_valid_q || !res_stall))
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (vec_valid) begin
						fn_q   <= func;
						pass_q <= 1'b0;
						sh30_q <= 1'b1;
						k_q    <= '0;
						ph_q   <= 1'b0;
						unique case (func) inside
							FN_INTEG: begin
								cnt_q   <= 6'd32;
								state_q <= S_HDIV;
							end
							FN_R2B, FN_B2R: state_q <= S_HP;
							default: begin
								orient_q[0] <= sat_cw(WIDE'(init_w_q));
								orient_q[1] <= sat_cw(WIDE'(init_x_q));
								orient_q[2] <= sat_cw(WIDE'(init_y_q));
								orient_q[3] <= sat_cw(WIDE'(init_z_q));
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_HDIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end else begin
						step_q  <= '0;
						sh30_q  <= 1'b0;
						k_q     <= '0;
						ph_q    <= 1'b0;
						state_q <= S_HP;
					end
				end
				S_HP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						k_q <= k_q + 4'd1;
						if (k_q == 4'd15)
							state_q <= S_HPEND;
					end
				end
				S_HPEND: begin
					if (fn_q == FN_INTEG) begin
						idx_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= S_SCALE;
					end else if (!pass_q) begin
						pass_q  <= 1'b1;
						k_q     <= '0;
						ph_q    <= 1'b0;
						state_q <= S_HP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCALE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						orient_q[idx_q] <= sat_cw(sc_sum);
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3)
							state_q <= S_NMAG;
					end
				end
				S_NMAG: state_q <= S_NSHIFT;
				S_NSHIFT: begin
					if (!big) begin
						idx_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= S_NSQ;
					end
				end
				S_NSQ: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							cnt_q   <= 6'd32;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end else if (quo_q != '0) begin
						idx_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= S_NDIV;
					end else if (step_q == steps - 8'd1) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= step_q + 8'd1;
						k_q     <= '0;
						ph_q    <= 1'b0;
						state_q <= S_HP;
					end
				end
				S_NDIV: begin
					if (!ph_q) begin
						cnt_q <= 6'd31;
						ph_q  <= 1'b1;
					end else if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end else begin
						orient_q[idx_q] <= sat_cw(nd_val);
						ph_q  <= 1'b0;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							if (step_q == steps - 8'd1) begin
								state_q <= S_DONE;
							end else begin
								step_q  <= step_q + 8'd1;
								k_q     <= '0;
								state_q <= S_HP;
							end
						end
					end
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign vec_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign out_w     = out_w_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	// an accepted transaction always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		vec_valid && !vec_stall |=> state_q != S_IDLE)
		else $error("accepted transaction did not start work");

	// normalized components never exceed one
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NDIV && ph_q && cnt_q == '0 |-> quo_q <= (64'd1 << 30))
		else $error("normalization quotient above one");

	// the w and z attitude components hold while quaternion products run
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HP |=> $stable(orient_q[0]) && $stable(orient_q[3]))
		else $error("attitude changed during product");

	// squares are summed only from magnitudes below the shift threshold
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NSQ |-> !big)
		else $error("unreduced magnitude in sum of squares");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall && state_q == S_DONE |=> state_q == S_DONE)
		else $error("result left done state while output stalled");

endmodule

// ===== bench/tb_quaternion_attitude_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_attitude_unit
// Drives rate integrations, frame rotations and attitude loads through the
// block under random handshake gaps and a series of register settings, and
// checks every result against a bit-exact fixed-point attitude predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_attitude_unit;
	import qau_pkg::*;

	typedef struct {
		logic signed [31:0] w, x, y, z;
	} quat_out_t;

	class attitude_scoreboard;
		longint q[4];
		longint init_q[4];
		longint unsigned dt;
		int unsigned nsub;
		quat_out_t pending[$];
		int errors;

		function new();
			init_q = '{longint'(1) << 30, 0, 0, 0};
			q = init_q;
			dt = 167772;
			nsub = 1;
			errors = 0;
		endfunction

		function longint sat_comp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// floor(a*b / 2^s), clamped to +-2^60
		function longint mul_shift(longint a, longint b, int s);
			logic signed [127:0] pa, pb, p, lim;
			pa = a;
			pb = b;
			lim = 128'sd1 <<< 60;
			p = (pa * pb) >>> s;
			if (p > lim) p = lim;
			if (p < -lim) p = -lim;
			return longint'(p);
		endfunction

		function void hamilton(input longint a[4], input longint b[4], int s,
				output longint r[4]);
			longint rw, rx, ry, rz;
			rw = -mul_shift(a[1], b[1], s) - mul_shift(a[2], b[2], s)
				- mul_shift(a[3], b[3], s) + mul_shift(a[0], b[0], s);
			rx = mul_shift(a[0], b[1], s) - mul_shift(a[3], b[2], s)
				+ mul_shift(a[2], b[3], s) + mul_shift(a[1], b[0], s);
			ry = mul_shift(a[3], b[1], s) + mul_shift(a[0], b[2], s)
				- mul_shift(a[1], b[3], s) + mul_shift(a[2], b[0], s);
			rz = -mul_shift(a[2], b[1], s) + mul_shift(a[1], b[2], s)
				+ mul_shift(a[0], b[3], s) + mul_shift(a[3], b[0], s);
			r = '{sat_comp(rw), sat_comp(rx), sat_comp(ry), sat_comp(rz)};
		endfunction

		function void conjugate(input longint a[4], output longint r[4]);
			r = '{a[0], sat_comp(-a[1]), sat_comp(-a[2]), sat_comp(-a[3])};
		endfunction

		function longint unsigned floor_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function void renormalize();
			longint unsigned c[4], m, sum, n;
			longint v;
			int k;
			m = 0;
			sum = 0;
			k = 0;
			for (int i = 0; i < 4; i++) begin
				c[i] = q[i] < 0 ? longint'(-q[i]) : longint'(q[i]);
				if (c[i] > m) m = c[i];
			end
			while ((m >> k) >= (64'd1 << 31)) k++;
			for (int i = 0; i < 4; i++) begin
				c[i] >>= k;
				sum += c[i] * c[i];
			end
			n = floor_sqrt(sum);
			if (n == 0) return;
			for (int i = 0; i < 4; i++) begin
				v = longint'((c[i] << 30) / n);
				q[i] = sat_comp(q[i] < 0 ? -v : v);
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_INIT_W:   init_q[0] = longint'(signed'(data));
				REG_INIT_X:   init_q[1] = longint'(signed'(data));
				REG_INIT_Y:   init_q[2] = longint'(signed'(data));
				REG_INIT_Z:   init_q[3] = longint'(signed'(data));
				REG_TIMESTEP: dt = data;
				REG_SUBSTEPS: nsub = data[7:0];
				default: ;
			endcase
		endfunction

		function void note_input(logic [1:0] f, logic signed [31:0] vx,
				logic signed [31:0] vy, logic signed [31:0] vz);
			longint v[4], t[4], cq[4], r[4];
			longint h;
			int unsigned steps;
			quat_out_t e;
			v = '{0, longint'(vx), longint'(vy), longint'(vz)};
			case (f)
				FN_INTEG: begin
					steps = nsub ? nsub : 1;
					h = longint'(dt / steps);
					for (int s = 0; s < steps; s++) begin
						hamilton(q, v, 20, t);
						for (int i = 0; i < 4; i++)
							q[i] = sat_comp(q[i] + mul_shift(t[i], h, 25));
						renormalize();
					end
					r = q;
				end
				FN_R2B: begin
					hamilton(v, q, 30, t);
					conjugate(q, cq);
					hamilton(cq, t, 30, r);
				end
				FN_B2R: begin
					conjugate(q, cq);
					hamilton(v, cq, 30, t);
					hamilton(q, t, 30, r);
				end
				default: begin
					for (int i = 0; i < 4; i++) q[i] = sat_comp(init_q[i]);
					r = q;
				end
			endcase
			e.w = r[0][31:0];
			e.x = r[1][31:0];
			e.y = r[2][31:0];
			e.z = r[3][31:0];
			pending.push_back(e);
		endfunction

		function void check_result(quat_out_t a);
			quat_out_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result w=%0d x=%0d y=%0d z=%0d", a.w, a.x, a.y, a.z);
				return;
			end
			e = pending.pop_front();
			if (a != e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
						e.w, e.x, e.y, e.z, a.w, a.x, a.y, a.z);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid = 1'b0;
	logic vec_stall;
	logic [1:0] func = FN_INTEG;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [31:0] out_w, out_x, out_y, out_z;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = REG_INIT_W;
	logic [31:0] cfg_data = '0;

	attitude_scoreboard sb = new();
	bit quiet = 0;

	always #5 clk = ~clk;

	quaternion_attitude_unit u_dut (.*);

	initial begin
		#200_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stalls between transactions
	initial begin
		int n;
		quat_out_t a;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = quiet ? 0 : $urandom_range(0, 14);
			if (n != 0) begin
				res_stall = 1'b1;
				repeat (n) @(negedge clk);
				res_stall = 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			a.w = out_w;
			a.x = out_x;
			a.y = out_y;
			a.z = out_z;
			sb.check_result(a);
		end
	end

	task automatic send_vec(logic [1:0] f, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap != 0) begin
			vec_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		vec_valid = 1'b1;
		func = f;
		vec_x = x;
		vec_y = y;
		vec_z = z;
		do @(posedge clk); while (vec_stall);
		sb.note_input(f, x, y, z);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		vec_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.write_reg(idx, data);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'h4000_0000;
			default: return 32'($signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
		endcase
	endfunction

	task automatic send_random();
		int sel;
		logic [31:0] x, y, z;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			x = $urandom;
			y = $urandom;
			z = $urandom;
		end else begin
			// moderate rates and short vectors, each component within +-2^26
			x = 32'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000);
			y = 32'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000);
			z = 32'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000);
		end
		if (sel < 8) send_vec(FN_LOAD, x, y, z);
		else if (sel < 50) send_vec(FN_INTEG, x, y, z);
		else if (sel < 75) send_vec(FN_R2B, x, y, z);
		else send_vec(FN_B2R, x, y, z);
	endtask

	initial begin
		logic [31:0] ts;
		int sub, cnt;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: defaults, extremes of every field
		send_vec(FN_R2B, 32'h4000_0000, 0, 0);
		send_vec(FN_B2R, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_vec(FN_INTEG, 32'h0010_0000, 0, 0);
		send_vec(FN_INTEG, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vec(FN_INTEG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(FN_R2B, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(FN_B2R, 32'hffff_ffff, 0, 32'h4000_0000);
		send_vec(FN_LOAD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_vec(FN_INTEG, 0, 0, 0);
		wait_idle();
		// zero time step and zero substeps, then a non-unit attitude
		write_reg(REG_TIMESTEP, 0);
		write_reg(REG_SUBSTEPS, 0);
		write_reg(REG_INIT_W, 32'h8000_0000);
		write_reg(REG_INIT_X, 32'h7fff_ffff);
		write_reg(REG_INIT_Y, 32'h8000_0000);
		write_reg(REG_INIT_Z, 32'h7fff_ffff);
		send_vec(FN_LOAD, 0, 0, 0);
		send_vec(FN_R2B, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000);
		send_vec(FN_B2R, 32'h8000_0000, 32'h7fff_ffff, 32'h4000_0000);
		send_vec(FN_INTEG, 32'h0100_0000, 0, 0);
		wait_idle();
		// all-zero attitude stays zero through renormalization
		for (int i = 0; i < 4; i++) write_reg(3'(REG_INIT_W + i), 0);
		write_reg(REG_TIMESTEP, 32'hffff_ffff);
		send_vec(FN_LOAD, 0, 0, 0);
		send_vec(FN_INTEG, 32'h7fff_ffff, 32'h8000_0000, 32'h0123_4567);
		send_vec(FN_R2B, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		wait_idle();
		// largest substep count, a few items only
		write_reg(REG_INIT_W, 32'h4000_0000);
		write_reg(REG_SUBSTEPS, 255);
		write_reg(REG_TIMESTEP, 32'h0100_0000);
		send_vec(FN_LOAD, 0, 0, 0);
		send_vec(FN_INTEG, 32'h0040_0000, 32'hffc0_0000, 32'h0020_0000);
		send_vec(FN_INTEG, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		wait_idle();

		for (int ph = 0; ph < 17; ph++) begin
			quiet = (ph % 5 == 2);
			for (int i = 0; i < 4; i++) write_reg(3'(REG_INIT_W + i), rand_comp());
			case ($urandom_range(0, 5))
				0: ts = 0;
				1: ts = 32'hffff_ffff;
				2: ts = $urandom;
				default: ts = $urandom_range(1000, 2_000_000);
			endcase
			sub = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 255 : $urandom_range(1, 3);
			// keep the large substep count to a short phase
			cnt = (sub > 3) ? 4 : 102;
			write_reg(REG_TIMESTEP, ts);
			write_reg(REG_SUBSTEPS, 8'(sub));
			send_vec(FN_LOAD, 0, 0, 0);
			repeat (cnt) send_random();
			wait_idle();
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/qau_pkg.sv
rtl/quaternion_attitude_unit.sv
bench/tb_quaternion_attitude_unit.sv
